### hw/rtl/pan_tilt_jog_controller_assert.svh
// ----------------------------------------------------------------------------
// Pan/tilt jog controller assertion macros
// Shared wrappers for concurrent checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_JOG_CONTROLLER_ASSERT_SVH
`define PAN_TILT_JOG_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PTJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ptj_pkg.sv
// ----------------------------------------------------------------------------
// ptj_pkg
// Types, register codes and reset values for the pan/tilt jog controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptj_pkg;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd500;
  localparam logic [7:0]  INTERVAL_RST   = 8'd10;
  localparam logic [7:0]  STEP_RST       = 8'd2;
  localparam logic [7:0]  PAN_START_RST  = 8'd0;
  localparam logic [7:0]  PAN_MAX_RST    = 8'd100;
  localparam logic [7:0]  TILT_START_RST = 8'd0;
  localparam logic [7:0]  TILT_MAX_RST   = 8'd150;

  // register index codes
  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_INTERVAL   = 3'd1,
    REG_STEP       = 3'd2,
    REG_PAN_START  = 3'd3,
    REG_PAN_MAX    = 3'd4,
    REG_TILT_START = 3'd5,
    REG_TILT_MAX   = 3'd6
  } cfg_idx_t;

  // jog direction
  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // motor drive command
  typedef enum logic [1:0] {
    CMD_STOP       = 2'd0,
    CMD_TURN_LEFT  = 2'd1,
    CMD_TURN_RIGHT = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [7:0]  ramp_interval_ticks;
    logic [7:0]  ramp_step;
    logic [7:0]  pan_start_speed;
    logic [7:0]  pan_max_speed;
    logic [7:0]  tilt_start_speed;
    logic [7:0]  tilt_max_speed;
  } ptj_cfg_t;

  typedef struct packed {
    logic right_button;
    logic left_button;
    logic up_button;
    logic down_button;
    logic pan_right_limit;
    logic pan_left_limit;
    logic tilt_up_limit;
    logic tilt_down_limit;
  } ptj_in_t;

  typedef struct packed {
    logic       pan_enable;
    logic [1:0] pan_command;
    logic [7:0] pan_speed;
    logic       tilt_enable;
    logic [1:0] tilt_command;
    logic [7:0] tilt_speed;
    logic [2:0] direction;
    logic [3:0] stop_latches;
  } ptj_out_t;

  // right and down drive with command 1, left and up with command 2
  function automatic cmd_t cmd_of(input logic [1:0] idx);
    return (idx == 2'd0 || idx == 2'd3) ? CMD_TURN_LEFT : CMD_TURN_RIGHT;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pan_tilt_jog_controller.sv
// ----------------------------------------------------------------------------
// pan_tilt_jog_controller
// Joystick jog controller for a pan/tilt head with limit-switch stops.
// ----------------------------------------------------------------------------
// One request is one millisecond tick of buttons and limit events; every tick
// yields one result with the motor drive, speeds, direction and stop latches.
// The block takes one request per clock cycle while in_stall is low. A
// request is captured in an input register, processed by single-pass logic
// against the controller state, and its result lands in an output register.
// A stalled output holds the input register, so in_stall follows out_stall
// only when both registers are full. Configuration writes are taken at any
// time (cfg_ready is always high) but are meant to happen while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "pan_tilt_jog_controller_assert.svh"

module pan_tilt_jog_controller import ptj_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ptj_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ptj_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ptj_cfg_t cfg_r;
  ptj_in_t  in_data_r;
  logic     in_valid_r;
  ptj_out_t out_data_r;
  logic     out_valid_r;
  logic     adv;
  logic [3:0] accept;
  ptj_out_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEBOUNCE_RST;
      cfg_r.ramp_interval_ticks <= INTERVAL_RST;
      cfg_r.ramp_step           <= STEP_RST;
      cfg_r.pan_start_speed     <= PAN_START_RST;
      cfg_r.pan_max_speed       <= PAN_MAX_RST;
      cfg_r.tilt_start_speed    <= TILT_START_RST;
      cfg_r.tilt_max_speed      <= TILT_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE:   cfg_r.debounce_ticks      <= cfg_data;
        REG_INTERVAL:   cfg_r.ramp_interval_ticks <= cfg_data[7:0];
        REG_STEP:       cfg_r.ramp_step           <= cfg_data[7:0];
        REG_PAN_START:  cfg_r.pan_start_speed     <= cfg_data[7:0];
        REG_PAN_MAX:    cfg_r.pan_max_speed       <= cfg_data[7:0];
        REG_TILT_START: cfg_r.tilt_start_speed    <= cfg_data[7:0];
        REG_TILT_MAX:   cfg_r.tilt_max_speed      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control: the held request moves when the output slot frees up
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_data_r <= in_data;
  end

  ptj_limit u_limit (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .lim_evt        ({in_data_r.tilt_down_limit, in_data_r.tilt_up_limit,
                      in_data_r.pan_left_limit, in_data_r.pan_right_limit}),
    .debounce_ticks (cfg_r.debounce_ticks),
    .accept         (accept)
  );

  ptj_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cfg_r),
    .btn    ({in_data_r.down_button, in_data_r.up_button,
              in_data_r.left_button, in_data_r.right_button}),
    .accept (accept),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stall only when both stages are full and the output is blocked
  `PTJ_ASSERT_IMP(a_stall_full, in_stall, in_valid_r && out_valid_r && out_stall, "stall without full pipe")
  // a blocked request stays in the input register
  `PTJ_ASSERT_NXT(a_hold_in, in_valid_r && !adv, in_valid_r, "held request dropped")
  // every advance produces a result
  `PTJ_ASSERT_NXT(a_adv_out, adv, out_valid_r, "advance without result")

endmodule

`default_nettype wire

### hw/rtl/ptj_limit.sv
// ----------------------------------------------------------------------------
// ptj_limit
// Per-switch debounce counters; flags limit events that pass the holdoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptj_limit import ptj_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic [3:0] lim_evt,
  input  wire logic [15:0] debounce_ticks,
  output logic [3:0]      accept
);

  logic [15:0] ticks_r   [4];
  logic [15:0] ticks_nxt [4];

  // advance each counter (saturating) and test the holdoff
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [15:0] el;
      el = (ticks_r[k] == TICK_MAX) ? TICK_MAX : ticks_r[k] + 16'd1;
      accept[k] = lim_evt[k] && ((el == TICK_MAX) || (el > debounce_ticks));
      ticks_nxt[k] = accept[k] ? 16'd0 : el;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) ticks_r[k] <= TICK_MAX;
    end else if (adv) begin
      for (int k = 0; k < 4; k++) ticks_r[k] <= ticks_nxt[k];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ptj_core.sv
// ----------------------------------------------------------------------------
// ptj_core
// Direction state machine, stop latches and speed ramp; one tick per advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pan_tilt_jog_controller_assert.svh"

module ptj_core import ptj_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire ptj_cfg_t cfg,
  input  wire logic [3:0] btn,
  input  wire logic [3:0] accept,
  output ptj_out_t      result
);

  dir_t       dir_r,    dir_nxt;
  logic       ramp_r,   ramp_nxt;
  logic [7:0] timer_r,  timer_nxt;
  logic [1:0] ridx_r,   ridx_nxt;
  logic [7:0] pspd_r,   pspd_nxt;
  logic [7:0] tspd_r,   tspd_nxt;
  logic       pen_r,    pen_nxt;
  logic       ten_r,    ten_nxt;
  cmd_t       pcmd_r,   pcmd_nxt;
  cmd_t       tcmd_r,   tcmd_nxt;
  logic [3:0] latch_r,  latch_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_STOP;
      ramp_r  <= 1'b0;
      timer_r <= 8'd0;
      ridx_r  <= 2'd0;
      pspd_r  <= 8'd0;
      tspd_r  <= 8'd0;
      pen_r   <= 1'b0;
      ten_r   <= 1'b0;
      pcmd_r  <= CMD_STOP;
      tcmd_r  <= CMD_STOP;
      latch_r <= 4'd0;
    end else if (adv) begin
      dir_r   <= dir_nxt;
      ramp_r  <= ramp_nxt;
      timer_r <= timer_nxt;
      ridx_r  <= ridx_nxt;
      pspd_r  <= pspd_nxt;
      tspd_r  <= tspd_nxt;
      pen_r   <= pen_nxt;
      ten_r   <= ten_nxt;
      pcmd_r  <= pcmd_nxt;
      tcmd_r  <= tcmd_nxt;
      latch_r <= latch_nxt;
    end
  end

  // next state: limit events, then ramp or selection, then latch check
  always_comb begin
    logic [2:0] d3;
    logic [1:0] hit;
    logic [1:0] sel;
    logic       started;
    logic       apply;
    logic [7:0] apply_s;
    logic [8:0] next_s;
    logic [7:0] mx;
    logic [7:0] st;
    logic [7:0] ival;

    dir_nxt   = dir_r;
    ramp_nxt  = ramp_r;
    timer_nxt = timer_r;
    ridx_nxt  = ridx_r;
    pspd_nxt  = pspd_r;
    tspd_nxt  = tspd_r;
    pen_nxt   = pen_r;
    ten_nxt   = ten_r;
    pcmd_nxt  = pcmd_r;
    tcmd_nxt  = tcmd_r;
    latch_nxt = latch_r;
    started   = 1'b0;
    sel       = 2'd0;
    apply     = 1'b0;
    apply_s   = 8'd0;
    next_s    = 9'd0;
    mx        = 8'd0;
    st        = 8'd0;
    ival      = (cfg.ramp_interval_ticks == 8'd0) ? 8'd1 : cfg.ramp_interval_ticks;

    // limit event: only the switch matching the current direction can latch
    d3  = dir_r;
    hit = d3[1:0] - 2'd1;
    if (dir_r != DIR_STOP && accept[hit] && !latch_r[hit]) begin
      latch_nxt[hit] = 1'b1;
      if (hit[1]) latch_nxt[hit ^ 2'd1] = 1'b0;
      dir_nxt = DIR_STOP;
    end

    if (ramp_r) begin
      // ramp step when the interval timer runs out
      timer_nxt = timer_r - 8'd1;
      if (timer_nxt == 8'd0) begin
        next_s = (ridx_r[1] ? {1'b0, tspd_r} : {1'b0, pspd_r}) + {1'b0, cfg.ramp_step};
        mx     = ridx_r[1] ? cfg.tilt_max_speed : cfg.pan_max_speed;
        if (next_s >= {1'b0, mx}) begin
          ramp_nxt = 1'b0;
        end else begin
          apply   = 1'b1;
          apply_s = next_s[7:0];
        end
      end
    end else begin
      // direction selection, priority right, left, up, down
      for (int k = 0; k < 4; k++) begin
        if (!started && btn[k] && dir_nxt != dir_t'(3'(k + 1)) && !latch_nxt[k]) begin
          started = 1'b1;
          sel     = k[1:0];
        end
      end
      if (started) begin
        latch_nxt[sel ^ 2'd1] = 1'b0;
        dir_nxt  = dir_t'({1'b0, sel} + 3'd1);
        ridx_nxt = sel;
        if (!sel[1]) begin
          pen_nxt = 1'b1;
          st = cfg.pan_start_speed;
          mx = cfg.pan_max_speed;
        end else begin
          ten_nxt = 1'b1;
          st = cfg.tilt_start_speed;
          mx = cfg.tilt_max_speed;
        end
        if (st < mx) begin
          ramp_nxt = 1'b1;
          apply    = 1'b1;
          apply_s  = st;
        end
      end else if (dir_nxt != DIR_STOP && btn == 4'd0) begin
        // all buttons released
        dir_nxt  = DIR_STOP;
        pen_nxt  = 1'b0;
        pcmd_nxt = CMD_STOP;
        pspd_nxt = 8'd0;
        ten_nxt  = 1'b0;
        tcmd_nxt = CMD_STOP;
        tspd_nxt = 8'd0;
      end
    end

    // apply a ramp speed; a released button or set latch ends the ramp
    if (apply) begin
      if (!ridx_nxt[1]) begin
        pcmd_nxt = cmd_of(ridx_nxt);
        pspd_nxt = apply_s;
      end else begin
        tcmd_nxt = cmd_of(ridx_nxt);
        tspd_nxt = apply_s;
      end
      if (!btn[ridx_nxt] || latch_nxt[ridx_nxt]) begin
        ramp_nxt = 1'b0;
        if (!ridx_nxt[1]) begin
          pen_nxt  = 1'b0;
          pcmd_nxt = CMD_STOP;
          pspd_nxt = 8'd0;
        end else begin
          ten_nxt  = 1'b0;
          tcmd_nxt = CMD_STOP;
          tspd_nxt = 8'd0;
        end
      end else begin
        timer_nxt = ival;
      end
    end

    // latch check outside a ramp
    if (!ramp_nxt && latch_nxt != 4'd0) begin
      dir_nxt  = DIR_STOP;
      pen_nxt  = 1'b0;
      pcmd_nxt = CMD_STOP;
      pspd_nxt = 8'd0;
      ten_nxt  = 1'b0;
      tcmd_nxt = CMD_STOP;
      tspd_nxt = 8'd0;
    end
  end

  // result is the state after this tick
  always_comb begin
    result.pan_enable   = pen_nxt;
    result.pan_command  = pcmd_nxt;
    result.pan_speed    = pspd_nxt;
    result.tilt_enable  = ten_nxt;
    result.tilt_command = tcmd_nxt;
    result.tilt_speed   = tspd_nxt;
    result.direction    = dir_nxt;
    result.stop_latches = latch_nxt;
  end

  // a running ramp always has its motor enabled and a live timer
  `PTJ_ASSERT_IMP(a_ramp_motor_en, ramp_r, (ridx_r[1] ? ten_r : pen_r), "ramp motor disabled")
  `PTJ_ASSERT_IMP(a_ramp_timer, ramp_r, timer_r != 8'd0, "ramp timer zero while active")
  // up and down latches are mutually exclusive
  `PTJ_ASSERT_IMP(a_tilt_latch, 1'b1, !(latch_r[2] && latch_r[3]), "both tilt latches set")

endmodule

`default_nettype wire

### verif/pan_tilt_jog_controller_tb.sv
// ----------------------------------------------------------------------------
// pan_tilt_jog_controller_tb
// Self-checking bench for the pan/tilt jog controller. A short table of
// directed ticks and register writes runs first, then phases of fixed and
// random register settings with held-button sequences, limit events and noise.
// Every accepted tick is run through a local model of the controller and
// each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pan_tilt_jog_controller_tb;
  import ptj_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASES          = 11;
  localparam int PHASE_TICKS     = 95;

  // tick bit masks, in ptj_in_t packing order
  localparam logic [7:0] BTN_R = 8'h80;
  localparam logic [7:0] BTN_L = 8'h40;
  localparam logic [7:0] BTN_U = 8'h20;
  localparam logic [7:0] BTN_D = 8'h10;
  localparam logic [7:0] LIM_R = 8'h08;
  localparam logic [7:0] LIM_L = 8'h04;
  localparam logic [7:0] LIM_U = 8'h02;
  localparam logic [7:0] LIM_D = 8'h01;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    ptj_in_t     tick;
    logic        fixed_en;
    ptj_out_t    fixed;
    cfg_idx_t    idx;
    logic [15:0] val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ptj_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ptj_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // expectation override for directed rows with a typed result
  logic        tick_fixed_en = 1'b0;
  ptj_out_t    tick_fixed = '0;

  ptj_out_t    drive_q [$];
  dir_row_t    dir_rows [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  logic        no_idle = 1'b0;

  // model copy of the register file
  logic [15:0] m_debounce;
  logic [7:0]  m_interval, m_step;
  logic [7:0]  m_pan_start, m_pan_max, m_tilt_start, m_tilt_max;

  // model copy of the controller state
  logic [2:0]  cur_dir, ramp_dir;
  logic        ramp_on;
  logic [7:0]  ramp_tmr, pan_spd, tilt_spd;
  logic [2:0]  pan_drv, tilt_drv;   // {enable, command}
  logic [3:0]  latch, held;         // bit0 right, bit1 left, bit2 up, bit3 down
  logic [15:0] since_evt [4];

  pan_tilt_jog_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Controller model
  // --------------------------------------------------------------------------
  function automatic void jog_reset();
    m_debounce = DEBOUNCE_RST;
    m_interval = INTERVAL_RST;
    m_step = STEP_RST;
    m_pan_start = PAN_START_RST;
    m_pan_max = PAN_MAX_RST;
    m_tilt_start = TILT_START_RST;
    m_tilt_max = TILT_MAX_RST;
    cur_dir = DIR_STOP;
    ramp_dir = DIR_STOP;
    ramp_on = 1'b0;
    ramp_tmr = '0;
    pan_spd = '0;
    tilt_spd = '0;
    pan_drv = '0;
    tilt_drv = '0;
    latch = '0;
    held = '0;
    for (int k = 0; k < 4; k++) since_evt[k] = TICK_MAX;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] v);
    case (cfg_idx_t'(idx))
      REG_DEBOUNCE:   m_debounce = v;
      REG_INTERVAL:   m_interval = v[7:0];
      REG_STEP:       m_step = v[7:0];
      REG_PAN_START:  m_pan_start = v[7:0];
      REG_PAN_MAX:    m_pan_max = v[7:0];
      REG_TILT_START: m_tilt_start = v[7:0];
      REG_TILT_MAX:   m_tilt_max = v[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic on_pan(logic [2:0] d);
    return d == DIR_RIGHT || d == DIR_LEFT;
  endfunction

  // right and down turn left, left and up turn right
  function automatic logic [1:0] dir_cmd(logic [2:0] d);
    return (d == DIR_RIGHT || d == DIR_DOWN) ? CMD_TURN_LEFT : CMD_TURN_RIGHT;
  endfunction

  function automatic void stop_motor(logic pan);
    if (pan) begin
      pan_drv = '0;
      pan_spd = '0;
    end else begin
      tilt_drv = '0;
      tilt_spd = '0;
    end
  endfunction

  // drive the ramp's motor at speed s; end the ramp on release or latch
  function automatic void ramp_drive(logic [7:0] s);
    logic [2:0] t;
    logic [1:0] i;
    t = ramp_dir - 3'd1;
    i = t[1:0];
    if (on_pan(ramp_dir)) begin
      pan_drv = {pan_drv[2], dir_cmd(ramp_dir)};
      pan_spd = s;
    end else begin
      tilt_drv = {tilt_drv[2], dir_cmd(ramp_dir)};
      tilt_spd = s;
    end
    if (!held[i] || latch[i]) begin
      stop_motor(on_pan(ramp_dir));
      ramp_on = 1'b0;
    end else begin
      ramp_tmr = (m_interval == 8'd0) ? 8'd1 : m_interval;
    end
  endfunction

  function automatic void start_jog(logic [2:0] d);
    logic [2:0] t;
    logic [1:0] i;
    logic [7:0] st, mx;
    t = d - 3'd1;
    i = t[1:0];
    latch[i ^ 2'd1] = 1'b0;
    cur_dir = d;
    ramp_dir = d;
    if (on_pan(d)) begin
      pan_drv[2] = 1'b1;
      st = m_pan_start;
      mx = m_pan_max;
    end else begin
      tilt_drv[2] = 1'b1;
      st = m_tilt_start;
      mx = m_tilt_max;
    end
    // start at or above max only enables the motor
    if (st < mx) begin
      ramp_on = 1'b1;
      ramp_drive(st);
    end
  endfunction

  function automatic ptj_out_t jog_tick(ptj_in_t r);
    logic [3:0]  lim;
    logic [15:0] el;
    logic        accept, started, pan;
    logic [8:0]  nxt;
    logic [7:0]  mx;
    ptj_out_t    res;
    held = {r.down_button, r.up_button, r.left_button, r.right_button};
    lim = {r.tilt_down_limit, r.tilt_up_limit, r.pan_left_limit, r.pan_right_limit};

    // debounced limit events
    for (int k = 0; k < 4; k++) begin
      el = (since_evt[k] == TICK_MAX) ? TICK_MAX : since_evt[k] + 16'd1;
      accept = (el == TICK_MAX) || (el > m_debounce);
      if (lim[k] && accept) begin
        if (!latch[k] && cur_dir == k + 1) begin
          latch[k] = 1'b1;
          if (k == 2) latch[3] = 1'b0;
          if (k == 3) latch[2] = 1'b0;
          cur_dir = DIR_STOP;
        end
        since_evt[k] = '0;
      end else begin
        since_evt[k] = el;
      end
    end

    // ramp step, or direction selection when no ramp runs
    if (ramp_on) begin
      ramp_tmr = ramp_tmr - 8'd1;
      if (ramp_tmr == 8'd0) begin
        pan = on_pan(ramp_dir);
        nxt = {1'b0, pan ? pan_spd : tilt_spd} + {1'b0, m_step};
        mx = pan ? m_pan_max : m_tilt_max;
        if (nxt >= {1'b0, mx}) ramp_on = 1'b0;
        else ramp_drive(nxt[7:0]);
      end
    end else begin
      started = 1'b0;
      for (int d = DIR_RIGHT; d <= DIR_DOWN && !started; d++) begin
        if (held[d-1] && cur_dir != d && !latch[d-1]) begin
          start_jog(3'(d));
          started = 1'b1;
        end
      end
      if (!started && cur_dir != DIR_STOP && held == 4'd0) begin
        cur_dir = DIR_STOP;
        stop_motor(1'b1);
        stop_motor(1'b0);
      end
    end

    // any latch stops everything once no ramp runs
    if (!ramp_on && latch != 4'd0) begin
      cur_dir = DIR_STOP;
      stop_motor(1'b1);
      stop_motor(1'b0);
    end

    res.pan_enable = pan_drv[2];
    res.pan_command = pan_drv[1:0];
    res.pan_speed = pan_spd;
    res.tilt_enable = tilt_drv[2];
    res.tilt_command = tilt_drv[1:0];
    res.tilt_speed = tilt_spd;
    res.direction = cur_dir;
    res.stop_latches = latch;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_tick(logic [7:0] v, logic fe, ptj_out_t fx);
    dir_row_t row;
    row.kind = ROW_TICK;
    row.tick = ptj_in_t'(v);
    row.fixed_en = fe;
    row.fixed = fx;
    row.idx = REG_DEBOUNCE;
    row.val = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_write(cfg_idx_t idx, logic [15:0] v);
    dir_row_t row;
    row.kind = ROW_WRITE;
    row.tick = '0;
    row.fixed_en = 1'b0;
    row.fixed = '0;
    row.idx = idx;
    row.val = v;
    dir_rows.push_back(row);
  endfunction

  task automatic check_field(string nm, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, exp_v, act_v);
      errors++;
    end
  endtask

  // drop the request line and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic reg_write(cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_tick(ptj_in_t req, logic fe, ptj_out_t fx);
    int gap;
    if (cfg_valid) cfg_valid <= 1'b0;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    tick_fixed_en <= fe;
    tick_fixed <= fx;
    do @(posedge clk); while (in_stall);
  endtask

  // --------------------------------------------------------------------------
  // Result-side stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: register writes, request prediction, result check, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_b
    ptj_out_t pred;
    ptj_out_t want;
    logic     moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        pred = jog_tick(in_data);
        drive_q.push_back(tick_fixed_en ? tick_fixed : pred);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (drive_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_data);
          errors++;
        end else begin
          want = drive_q.pop_front();
          check_field("pan_enable", want.pan_enable, out_data.pan_enable);
          check_field("pan_command", want.pan_command, out_data.pan_command);
          check_field("pan_speed", want.pan_speed, out_data.pan_speed);
          check_field("tilt_enable", want.tilt_enable, out_data.tilt_enable);
          check_field("tilt_command", want.tilt_command, out_data.tilt_command);
          check_field("tilt_speed", want.tilt_speed, out_data.tilt_speed);
          check_field("direction", want.direction, out_data.direction);
          check_field("stop_latches", want.stop_latches, out_data.stop_latches);
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("pan_tilt_jog_controller_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim_b
    int          hold_left;
    int          r;
    logic [3:0]  pattern;
    logic [7:0]  lim;
    ptj_in_t     req;
    logic [15:0] rv [7];
    ptj_out_t    zero_out;

    jog_reset();
    hold_left = 0;
    pattern = '0;
    zero_out = '0;

    // directed table; typed results only where obvious
    add_write(REG_INTERVAL, 16'd0);     // zero interval acts as one
    add_write(REG_STEP, 16'd3);
    add_write(REG_PAN_MAX, 16'd8);
    add_write(REG_TILT_START, 16'd200); // tilt start above max
    add_write(REG_TILT_MAX, 16'd100);
    add_write(REG_DEBOUNCE, 16'd0);
    add_tick(8'h00, 1'b1, zero_out);
    add_tick(BTN_R, 1'b1, '{1'b1, CMD_TURN_LEFT, 8'd0, 1'b0, CMD_STOP, 8'd0,
                           DIR_RIGHT, 4'b0000});
    // first limit event after reset is taken and latches right
    add_tick(BTN_R | LIM_R, 1'b1, '{1'b0, CMD_STOP, 8'd0, 1'b0, CMD_STOP, 8'd0,
                                   DIR_STOP, 4'b0001});
    add_tick(BTN_R, 1'b0, zero_out);
    add_tick(BTN_L, 1'b0, zero_out);
    add_tick(BTN_L, 1'b0, zero_out);
    add_tick(BTN_L, 1'b0, zero_out);
    add_tick(BTN_L, 1'b0, zero_out);
    add_tick(BTN_L | LIM_L, 1'b0, zero_out);
    add_tick(BTN_R, 1'b0, zero_out);
    add_tick(8'h00, 1'b0, zero_out);
    add_tick(8'h00, 1'b0, zero_out);
    add_tick(BTN_U, 1'b0, zero_out);
    add_tick(BTN_U | LIM_U, 1'b0, zero_out);
    add_tick(BTN_D, 1'b0, zero_out);
    add_tick(BTN_D | LIM_D, 1'b0, zero_out);
    add_tick(BTN_R | BTN_L | BTN_U | BTN_D, 1'b0, zero_out);
    add_tick(LIM_R | LIM_L | LIM_U | LIM_D, 1'b0, zero_out);
    add_tick(8'hFF, 1'b0, zero_out);
    add_tick(8'h00, 1'b0, zero_out);
    // zero step, start equal to max, longest debounce
    add_write(REG_STEP, 16'd0);
    add_write(REG_INTERVAL, 16'd2);
    add_write(REG_PAN_START, 16'd255);
    add_write(REG_PAN_MAX, 16'd255);
    add_write(REG_TILT_START, 16'd0);
    add_write(REG_TILT_MAX, 16'd255);
    add_write(REG_DEBOUNCE, 16'd65535);
    add_tick(BTN_D, 1'b0, zero_out);
    add_tick(BTN_D, 1'b0, zero_out);
    add_tick(BTN_D | LIM_D, 1'b0, zero_out);
    add_tick(BTN_D, 1'b0, zero_out);
    add_tick(8'h00, 1'b0, zero_out);
    add_tick(BTN_R, 1'b0, zero_out);
    add_tick(8'h00, 1'b0, zero_out);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (!cfg_valid) wait_idle();
        reg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].tick, dir_rows[i].fixed_en, dir_rows[i].fixed);
      end
    end

    // phases, each with its own register setting; fixed for the first three, then random
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          rv[REG_DEBOUNCE] = 16'd0;
          rv[REG_INTERVAL] = 16'd1;
          rv[REG_STEP] = 16'd1;
          rv[REG_PAN_START] = 16'd0;
          rv[REG_PAN_MAX] = 16'd0;
          rv[REG_TILT_START] = 16'd0;
          rv[REG_TILT_MAX] = 16'd255;
        end
        1: begin
          rv[REG_DEBOUNCE] = 16'd65535;
          rv[REG_INTERVAL] = 16'd255;
          rv[REG_STEP] = 16'd255;
          rv[REG_PAN_START] = 16'd255;
          rv[REG_PAN_MAX] = 16'd255;
          rv[REG_TILT_START] = 16'd254;
          rv[REG_TILT_MAX] = 16'd255;
        end
        2: begin
          rv[REG_DEBOUNCE] = 16'd1;
          rv[REG_INTERVAL] = 16'd1;
          rv[REG_STEP] = 16'd255;
          rv[REG_PAN_START] = 16'd0;
          rv[REG_PAN_MAX] = 16'd255;
          rv[REG_TILT_START] = 16'd254;
          rv[REG_TILT_MAX] = 16'd255;
        end
        default: begin
          rv[REG_DEBOUNCE] = ($urandom_range(0, 4) == 0) ?
                             16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 40));
          rv[REG_INTERVAL] = ($urandom_range(0, 5) == 0) ?
                             16'($urandom_range(1, 255)) : 16'($urandom_range(1, 4));
          rv[REG_STEP] = ($urandom_range(0, 5) == 0) ?
                         16'($urandom_range(0, 255)) : 16'($urandom_range(1, 40));
          rv[REG_PAN_START] = ($urandom_range(0, 3) == 0) ?
                              16'($urandom_range(0, 255)) : 16'($urandom_range(0, 30));
          rv[REG_PAN_MAX] = ($urandom_range(0, 3) == 0) ?
                            16'($urandom_range(0, 255)) : 16'($urandom_range(60, 255));
          rv[REG_TILT_START] = ($urandom_range(0, 3) == 0) ?
                               16'($urandom_range(0, 255)) : 16'($urandom_range(0, 30));
          rv[REG_TILT_MAX] = ($urandom_range(0, 3) == 0) ?
                             16'($urandom_range(0, 255)) : 16'($urandom_range(60, 255));
        end
      endcase
      wait_idle();
      no_idle = (ph % 4 == 3);
      for (int k = 0; k < 7; k++) reg_write(cfg_idx_t'(k), rv[k]);

      for (int n = 0; n < PHASE_TICKS; n++) begin
        // held-button runs: mostly one direction, some none or several
        if (hold_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) pattern = 4'b0001 << $urandom_range(0, 3);
          else if (r < 70) pattern = 4'b0000;
          else pattern = 4'($urandom_range(0, 15));
          hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 25);
        end
        hold_left--;
        lim = '0;
        for (int b = 0; b < 4; b++) lim[b] = ($urandom_range(0, 11) == 0);
        req.right_button = pattern[0];
        req.left_button = pattern[1];
        req.up_button = pattern[2];
        req.down_button = pattern[3];
        req.pan_right_limit = lim[0];
        req.pan_left_limit = lim[1];
        req.tilt_up_limit = lim[2];
        req.tilt_down_limit = lim[3];
        // occasional noise tick
        if ($urandom_range(0, 15) == 0) req = ptj_in_t'($urandom_range(0, 255));
        send_tick(req, 1'b0, zero_out);
      end
    end

    // drain and settle
    no_idle = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("pan_tilt_jog_controller_tb: PASS");
    end else begin
      $display("pan_tilt_jog_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
